[sv/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

  // Request action codes
  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [1:0] ACT_LIST    = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Per-cycle operation applied to every cell of the chain
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_ROTATE = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic       le_prev;  // insert position is below this cell
    logic       le;       // insert position is at or below this cell
  } cell_ctl_t;

endpackage

[sv/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cell_ctl_t          ctl,
  input  logic signed [31:0] new_data,
  input  logic signed [31:0] new_priority,
  input  logic               prev_valid,
  input  logic signed [31:0] prev_data,
  input  logic signed [31:0] prev_priority,
  input  logic               next_valid,
  input  logic signed [31:0] next_data,
  input  logic signed [31:0] next_priority,
  input  logic signed [31:0] head_data,
  input  logic signed [31:0] head_priority,
  output logic               valid,
  output logic signed [31:0] data,
  output logic signed [31:0] priority_q,
  output logic               ge,       // empty, or priority not below the new one
  output logic               new_lt    // new priority strictly below this one
);

  // Compare against the incoming priority
  assign ge     = !valid || !(priority_q < new_priority);
  assign new_lt = new_priority < priority_q;

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (ctl.cmd)
        CMD_INSERT: begin
          if (ctl.le_prev) valid <= prev_valid;
          else if (ctl.le) valid <= 1'b1;
        end
        CMD_REMOVE: valid <= next_valid;
        CMD_ROTATE, CMD_HOLD: ;
      endcase
    end
  end

  // Payload: shift in from either neighbor, take the new entry, or wrap the head
  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CMD_INSERT: begin
        if (ctl.le_prev) begin
          data       <= prev_data;
          priority_q <= prev_priority;
        end else if (ctl.le) begin
          data       <= new_data;
          priority_q <= new_priority;
        end
      end
      CMD_REMOVE: begin
        data       <= next_data;
        priority_q <= next_priority;
      end
      CMD_ROTATE: begin
        if (next_valid) begin
          data       <= next_data;
          priority_q <= next_priority;
        end else if (valid) begin
          data       <= head_data;
          priority_q <= head_priority;
        end
      end
      CMD_HOLD: ;
    endcase
  end

endmodule

[sv/sorted_priority_queue_core.sv]
`timescale 1ns / 1ps
// The first result of a request is registered and on the outputs in the cycle after it is taken.
// Enqueue and dequeue leave busy low, so the block can take the next request
// right away; a list rotates the chain through its head, issuing the stored
// entries in order, with busy high until the last entry issues.
// Reset (rst, synchronous): clears all valid bits, the count, busy and the strobe.
// The receiver cannot stall: each result stands for exactly one cycle.
module sorted_priority_queue_core import spq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic signed [31:0] in_data,
  input  logic signed [31:0] in_priority,
  output logic               result_valid,
  output logic [1:0]         status,
  output logic signed [31:0] out_data,
  output logic signed [31:0] out_priority,
  output logic               last
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic               cvalid [CAPACITY];
  logic signed [31:0] cdata  [CAPACITY];
  logic signed [31:0] cprio  [CAPACITY];
  logic               cge    [CAPACITY];
  logic               clt    [CAPACITY];
  logic [CAPACITY-1:0] le;
  logic [1:0]          cmd;
  logic                accept, full, empty, at_head;
  logic [CW-1:0]       count, remaining;

  assign accept  = start && !busy;
  assign full    = cvalid[CAPACITY-1];
  assign empty   = !cvalid[0];
  assign at_head = !cvalid[0] || clt[0];

  // Insert position decode: monotone past the head
  always_comb begin
    le[0] = at_head;
    for (int i = 1; i < CAPACITY; i++) le[i] = at_head || cge[i];
  end

  // Chain operation for this cycle
  always_comb begin
    cmd = CMD_HOLD;
    if (busy) begin
      cmd = CMD_ROTATE;
    end else if (accept) begin
      unique case (action)
        ACT_ENQUEUE: if (!full)  cmd = CMD_INSERT;
        ACT_DEQUEUE: if (!empty) cmd = CMD_REMOVE;
        ACT_LIST:    if (!empty) cmd = CMD_ROTATE;
        default:     cmd = CMD_HOLD;
      endcase
    end
  end

  // Cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    cell_ctl_t          ctl;
    logic               pv, nv;
    logic signed [31:0] pd, pp, nd, np;

    if (g == 0) begin : g_first
      assign pv = 1'b0;
      assign pd = '0;
      assign pp = '0;
      assign ctl.le_prev = 1'b0;
    end else begin : g_mid
      assign pv = cvalid[g-1];
      assign pd = cdata[g-1];
      assign pp = cprio[g-1];
      assign ctl.le_prev = le[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign nv = 1'b0;
      assign nd = '0;
      assign np = '0;
    end else begin : g_inner
      assign nv = cvalid[g+1];
      assign nd = cdata[g+1];
      assign np = cprio[g+1];
    end

    assign ctl.cmd = cmd;
    assign ctl.le  = le[g];

    spq_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .new_data      (in_data),
      .new_priority  (in_priority),
      .prev_valid    (pv),
      .prev_data     (pd),
      .prev_priority (pp),
      .next_valid    (nv),
      .next_data     (nd),
      .next_priority (np),
      .head_data     (cdata[0]),
      .head_priority (cprio[0]),
      .valid         (cvalid[g]),
      .data          (cdata[g]),
      .priority_q    (cprio[g]),
      .ge            (cge[g]),
      .new_lt        (clt[g])
    );
  end

  // Entry count and list sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      busy      <= 1'b0;
      remaining <= '0;
    end else begin
      if (cmd == CMD_INSERT) count <= count + CW'(1);
      else if (cmd == CMD_REMOVE) count <= count - CW'(1);

      if (busy) begin
        remaining <= remaining - CW'(1);
        busy      <= (remaining != CW'(1));
      end else if (accept && action == ACT_LIST && !empty) begin
        remaining <= count - CW'(1);
        busy      <= (count != CW'(1));
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= busy || (accept && (action == ACT_ENQUEUE ||
                      action == ACT_DEQUEUE || action == ACT_LIST));
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    status       <= ST_OK;
    out_data     <= '0;
    out_priority <= '0;
    last         <= 1'b1;
    if (busy) begin
      out_data     <= cdata[0];
      out_priority <= cprio[0];
      last         <= (remaining == CW'(1));
    end else begin
      unique case (action)
        ACT_ENQUEUE: if (full) status <= ST_FULL;
        ACT_DEQUEUE: begin
          if (empty) begin
            status <= ST_EMPTY;
          end else begin
            out_data     <= cdata[0];
            out_priority <= cprio[0];
          end
        end
        ACT_LIST: begin
          if (empty) begin
            status <= ST_EMPTY;
          end else begin
            out_data     <= cdata[0];
            out_priority <= cprio[0];
            last         <= (count == CW'(1));
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[tb/sv/tb_sorted_priority_queue_core.sv]
`timescale 1ns / 1ps

module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_REQUESTS = 86;
  localparam int CALM_TAIL = 30;
  localparam int CYCLE_LIMIT = 100000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // One result as it shows on the output ports
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic signed [31:0] prio;
    logic               last;
  } pq_result_t;

  // Shadow copy of the sorted list plus the results still owed by the block
  class pq_scoreboard;
    logic signed [31:0] shadow_data [DEPTH];
    logic signed [31:0] shadow_prio [DEPTH];
    int                 shadow_count;
    pq_result_t         due_results [$];
    int                 mismatches;
    int                 checked;
    int                 peak_count;
    int                 full_drops;

    function new();
      shadow_count = 0;
      mismatches   = 0;
      checked      = 0;
      peak_count   = 0;
      full_drops   = 0;
    endfunction

    function void owe(logic [1:0] st, logic signed [31:0] d, logic signed [31:0] p,
                      logic lst);
      pq_result_t r;
      r.status = st;
      r.data   = d;
      r.prio   = p;
      r.last   = lst;
      due_results.push_back(r);
    endfunction

    // Apply one accepted request to the shadow list and queue its results
    function void note_request(logic [1:0] act, logic signed [31:0] d,
                               logic signed [31:0] p);
      int pos;
      case (act)
        ACT_ENQUEUE: begin
          if (shadow_count >= DEPTH) begin
            owe(ST_FULL, 32'sd0, 32'sd0, 1'b1);
            full_drops++;
          end else begin
            // strictly below head goes first; head ties land behind it
            if (shadow_count == 0 || p < shadow_prio[0]) begin
              pos = 0;
            end else begin
              pos = 1;
              while (pos < shadow_count && shadow_prio[pos] < p) pos++;
            end
            for (int i = shadow_count; i > pos; i--) begin
              shadow_data[i] = shadow_data[i-1];
              shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_data[pos] = d;
            shadow_prio[pos] = p;
            shadow_count++;
            if (shadow_count > peak_count) peak_count = shadow_count;
            owe(ST_OK, 32'sd0, 32'sd0, 1'b1);
          end
        end
        ACT_DEQUEUE: begin
          if (shadow_count == 0) begin
            owe(ST_EMPTY, 32'sd0, 32'sd0, 1'b1);
          end else begin
            owe(ST_OK, shadow_data[0], shadow_prio[0], 1'b1);
            for (int i = 1; i < shadow_count; i++) begin
              shadow_data[i-1] = shadow_data[i];
              shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_count--;
          end
        end
        ACT_LIST: begin
          if (shadow_count == 0) begin
            owe(ST_EMPTY, 32'sd0, 32'sd0, 1'b1);
          end else begin
            for (int i = 0; i < shadow_count; i++)
              owe(ST_OK, shadow_data[i], shadow_prio[i], (i == shadow_count - 1));
          end
        end
        default: ; // unused code: no result, no change
      endcase
    endfunction

    // Compare one strobed result against the oldest owed one
    function void check_result(pq_result_t got);
      pq_result_t want;
      checked++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result status=%0d data=%0d prio=%0d last=%0d",
                   got.status, got.data, got.prio, got.last);
        return;
      end
      want = due_results.pop_front();
      if (got.status !== want.status || got.data !== want.data ||
          got.prio !== want.prio || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d exp status=%0d data=%0d prio=%0d last=%0d, got status=%0d data=%0d prio=%0d last=%0d",
                   checked, want.status, want.data, want.prio, want.last,
                   got.status, got.data, got.prio, got.last);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [1:0]         action = ACT_ENQUEUE;
  logic signed [31:0] in_data = 32'sd0;
  logic signed [31:0] in_priority = 32'sd0;
  logic               busy;
  logic               result_valid;
  logic [1:0]         status;
  logic signed [31:0] out_data;
  logic signed [31:0] out_priority;
  logic               last;

  pq_scoreboard sb = new();
  int           req_count [4];
  int           cycle_count = 0;

  sorted_priority_queue_core #(.CAPACITY(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .in_data      (in_data),
    .in_priority  (in_priority),
    .result_valid (result_valid),
    .status       (status),
    .out_data     (out_data),
    .out_priority (out_priority),
    .last         (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result monitor: every strobe is taken, the receiver never stalls
  always @(posedge clk) begin
    if (!rst && result_valid)
      sb.check_result('{status: status, data: out_data, prio: out_priority, last: last});
  end

  // Raise a request and hold it until the edge that takes it
  task automatic send_request(input logic [1:0] act, input logic signed [31:0] d,
                              input logic signed [31:0] p);
    start       <= 1'b1;
    action      <= act;
    in_data     <= d;
    in_priority <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(act, d, p);
    req_count[act]++;
  endtask

  task automatic idle_burst(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  // Priorities lean toward ties and extremes so ordering rules get exercised
  function automatic logic signed [31:0] pick_priority();
    int r;
    r = $urandom_range(0, 3);
    case (r)
      0: pick_priority = $urandom;
      1: pick_priority = int'($urandom_range(0, 10)) - 5;
      2: pick_priority = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: begin
        if (sb.shadow_count > 0)
          pick_priority = sb.shadow_prio[$urandom_range(0, sb.shadow_count - 1)];
        else
          pick_priority = $urandom;
      end
    endcase
  endfunction

  initial begin
    int         sent;
    int         bias;
    int         roll;
    logic [1:0] act;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cases, head insert, head tie, later tie, extremes
    send_request(ACT_DEQUEUE, 32'sd0, 32'sd0);
    send_request(ACT_LIST, 32'sd0, 32'sd0);
    send_request(ACT_ENQUEUE, 32'sh7fffffff, 32'sd0);
    send_request(ACT_ENQUEUE, 32'sh80000000, 32'sh80000000);
    send_request(ACT_ENQUEUE, 32'shffffffff, 32'sh80000000);
    send_request(ACT_ENQUEUE, 32'sd0, 32'sh7fffffff);
    send_request(ACT_ENQUEUE, 32'sh12345678, 32'sd0);
    send_request(ACT_ENQUEUE, 32'sh5a5a5a5a, -32'sd1);
    send_request(ACT_LIST, 32'sd0, 32'sd0);
    send_request(ACT_UNUSED, 32'shdeadbeef, 32'sh0badcafe);
    send_request(ACT_DEQUEUE, 32'sd0, 32'sd0);
    // fill to capacity and overflow by one
    for (int i = 0; i < 12; i++)
      send_request(ACT_ENQUEUE, $urandom,
                   (i % 3 == 0) ? 32'sh7fffffff : int'($urandom_range(0, 8)) - 4);
    send_request(ACT_LIST, 32'sd0, 32'sd0);
    drain();

    // Random: fill, drain and mixed phases so the list runs empty and full
    sent = 0;
    bias = 2;
    while (sent < RANDOM_REQUESTS) begin
      if (sent % 25 == 0) bias = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 3)
        act = ACT_UNUSED;
      else if (roll < 13)
        act = ACT_LIST;
      else if (bias == 0)
        act = (roll < 85) ? ACT_ENQUEUE : ACT_DEQUEUE;
      else if (bias == 1)
        act = (roll < 33) ? ACT_ENQUEUE : ACT_DEQUEUE;
      else
        act = (roll < 58) ? ACT_ENQUEUE : ACT_DEQUEUE;

      send_request(act, $urandom, pick_priority());
      if (act != ACT_UNUSED) sent++;

      if (sent == RANDOM_REQUESTS / 2) drain();
      else if (sent < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 3) == 0)
        idle_burst($urandom_range(1, 15));
    end

    drain();
    repeat (8) @(posedge clk);

    if (sb.due_results.size() != 0) begin
      sb.mismatches++;
      $display("ERROR: %0d results never arrived", sb.due_results.size());
    end
    $display("Covered %0d enqueues (%0d dropped full), %0d dequeues, %0d lists, %0d unused codes",
             req_count[ACT_ENQUEUE], sb.full_drops, req_count[ACT_DEQUEUE],
             req_count[ACT_LIST], req_count[ACT_UNUSED]);
    $display("Checked %0d results, peak fill %0d of %0d, %0d mismatches",
             sb.checked, sb.peak_count, DEPTH, sb.mismatches);
    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_core.sv
tb/sv/tb_sorted_priority_queue_core.sv
